FILE: sv/tcw_pkg.sv
// shared constants, register map and address helpers for the text console writer
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS + 1);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int PADDR_W = 4;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'd15;
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_SETPOS = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] REG_ATTR  = 2'd0;
  localparam logic [1:0] REG_BEGIN = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;
  localparam logic [1:0] REG_CURS  = 2'd3;

  // first cell of a row, also valid for the row just past the screen
  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r);
    row_base = ADDR_W'(int'(r) * COLS);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * COLS + int'(c));
  endfunction

endpackage
`default_nettype wire

FILE: sv/text_console_writer.sv
// text console engine: cell store, cursor and scroll sequencer
//
// Usage: items arrive on item_valid/item_ready with kind, char_code, row and
// col; each item gives exactly one result word on result_valid/result_ready
// carrying the cursor, its linear location, the cursor enable and, for a
// read, the cell contents. Configuration registers sit on the apb-style port
// at byte offsets 0 (attribute), 4 (scroll begin), 8 (scroll end) and
// 12 (cursor enable); pready is always high.
// Sequencing: a plain put char, set position or read cell is taken in S_IDLE
// and its result is loaded from S_DONE; no new item is taken until S_IDLE. A
// put char that scrolls first copies each cell of the region one row up
// (S_COPY, S_COPYEND), then blanks the bottom row (S_BLANK); a one-row
// region only blanks it. The cell ram has a single write port. Clear
// screen sweeps all 2000 cells, one a cycle.
// Reset: cursor goes home, registers take their reset values, and a
// clearing pass fills all 2000 cells with blanks (attribute 15);
// item_ready stays low during it while register writes are still taken.
// Stall: the result sits in an output register; if the receiver holds
// result_ready low the next item can still be accepted and worked on, and
// waits only when its own result is due.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_ready,
  input  wire logic [1:0]                   kind,
  input  wire logic [7:0]                   char_code,
  input  wire logic [5:0]                   row,
  input  wire logic [6:0]                   col,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
  output logic [tcw_pkg::COL_W-1:0]         cursor_col,
  output logic [10:0]                       cursor_offset,
  output logic                              cursor_enabled,
  output logic [15:0]                       cell_value,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int CW = tcw_pkg::COL_W;

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DONE    = 3'd2;
  localparam logic [2:0] S_COPY    = 3'd3;
  localparam logic [2:0] S_COPYEND = 3'd4;
  localparam logic [2:0] S_BLANK   = 3'd5;
  localparam logic [2:0] S_CLEAR   = 3'd6;

  // configuration registers
  logic [7:0]    text_attr;
  logic [RW-1:0] scroll_begin;
  logic [RW-1:0] scroll_end;
  logic          cursor_on;

  logic [2:0]    state;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [AW-1:0] ptr;
  logic [AW-1:0] stop;
  logic [AW-1:0] cp_waddr;
  logic          cp_pend;
  logic          read_hit;
  logic [AW-1:0] rd_addr;

  logic          accept;
  logic          cfg_write;
  logic          load_result;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;

  // put char decode
  logic [RW-1:0] p_row;
  logic [CW-1:0] p_col;
  logic          p_we;
  logic [AW-1:0] p_addr;
  logic [15:0]   p_data;
  logic [RW-1:0] e_eff;
  logic [RW-1:0] b_eff;
  logic          scroll_hit;
  logic          copy_any;
  logic          rd_in_range;
  logic [15:0]   blank_cur;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign blank_cur  = {text_attr, tcw_pkg::BLANK_CHAR};
  assign rd_in_range = (int'(row) < tcw_pkg::ROWS) && (int'(col) < tcw_pkg::COLS);
  assign load_result = (state == S_DONE) && (!result_valid || result_ready);

  always_comb begin
    case (paddr[3:2])
      tcw_pkg::REG_ATTR:  prdata = {24'd0, text_attr};
      tcw_pkg::REG_BEGIN: prdata = {27'd0, scroll_begin};
      tcw_pkg::REG_END:   prdata = {27'd0, scroll_end};
      tcw_pkg::REG_CURS:  prdata = {31'd0, cursor_on};
      default:            prdata = 32'd0;
    endcase
  end

  always_comb begin
    p_row  = cur_row;
    p_col  = cur_col;
    p_we   = 1'b0;
    p_addr = tcw_pkg::cell_addr(cur_row, cur_col);
    p_data = {text_attr, char_code};
    case (char_code)
      tcw_pkg::CH_LF: begin
        p_col = '0;
        p_row = RW'(cur_row + 1'b1);
      end
      tcw_pkg::CH_CR: begin
        p_col = '0;
      end
      tcw_pkg::CH_BS: begin
        if (cur_col != '0) begin
          p_col  = CW'(cur_col - 1'b1);
          p_we   = 1'b1;
          p_addr = tcw_pkg::cell_addr(cur_row, CW'(cur_col - 1'b1));
          p_data = blank_cur;
        end
      end
      default: begin
        p_we  = 1'b1;
        p_col = CW'(cur_col + 1'b1);
      end
    endcase
    if (int'(p_col) >= tcw_pkg::COLS) begin
      p_col = '0;
      p_row = RW'(p_row + 1'b1);
    end
    // effective scroll region
    e_eff = (int'(scroll_end) > tcw_pkg::ROWS) ? RW'(tcw_pkg::ROWS) : scroll_end;
    b_eff = scroll_begin;
    if (b_eff >= e_eff) begin
      b_eff = '0;
      e_eff = RW'(tcw_pkg::ROWS);
    end
    scroll_hit = (p_row >= e_eff);
    copy_any   = ({1'b0, b_eff} + 1'b1 < {1'b0, e_eff});
    if (scroll_hit) begin
      p_row = RW'(e_eff - 1'b1);
    end
  end

  // ram access mux
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = blank_cur;
    ram_raddr = ptr;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      end
      S_IDLE: begin
        ram_we    = accept && (kind == tcw_pkg::KIND_PUT) && p_we;
        ram_waddr = p_addr;
        ram_wdata = p_data;
        ram_raddr = tcw_pkg::cell_addr(row[RW-1:0], col);
      end
      S_DONE: begin
        // keep the read cell on the ram output while the result waits
        ram_raddr = rd_addr;
      end
      S_COPY, S_COPYEND: begin
        ram_we    = cp_pend;
        ram_waddr = cp_waddr;
        ram_wdata = ram_rdata;
      end
      S_BLANK, S_CLEAR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr      <= tcw_pkg::RESET_ATTR;
      scroll_begin   <= '0;
      scroll_end     <= RW'(tcw_pkg::ROWS);
      cursor_on      <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        tcw_pkg::REG_ATTR:  text_attr      <= pwdata[7:0];
        tcw_pkg::REG_BEGIN: scroll_begin   <= pwdata[RW-1:0];
        tcw_pkg::REG_END:   scroll_end     <= pwdata[RW-1:0];
        tcw_pkg::REG_CURS:  cursor_on      <= pwdata[0];
        default:            text_attr      <= text_attr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      ptr          <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      cp_pend      <= 1'b0;
      read_hit     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (int'(ptr) == tcw_pkg::CELLS - 1) begin
            state <= S_IDLE;
          end else begin
            ptr <= AW'(ptr + 1'b1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            rd_addr  <= tcw_pkg::cell_addr(row[RW-1:0], col);
            read_hit <= (kind == tcw_pkg::KIND_READ) && rd_in_range;
            case (kind)
              tcw_pkg::KIND_PUT: begin
                cur_row <= p_row;
                cur_col <= p_col;
                if (scroll_hit) begin
                  stop    <= AW'(tcw_pkg::row_base(e_eff) - 1'b1);
                  cp_pend <= 1'b0;
                  if (copy_any) begin
                    ptr   <= tcw_pkg::row_base(RW'(b_eff + 1'b1));
                    state <= S_COPY;
                  end else begin
                    ptr   <= tcw_pkg::row_base(RW'(e_eff - 1'b1));
                    state <= S_BLANK;
                  end
                end else begin
                  state <= S_DONE;
                end
              end
              tcw_pkg::KIND_CLEAR: begin
                cur_row <= '0;
                cur_col <= '0;
                ptr     <= '0;
                state   <= S_CLEAR;
              end
              tcw_pkg::KIND_SETPOS: begin
                cur_row <= (int'(row) >= tcw_pkg::ROWS) ? RW'(tcw_pkg::ROWS - 1)
                                                        : row[RW-1:0];
                cur_col <= (int'(col) >= tcw_pkg::COLS) ? CW'(tcw_pkg::COLS - 1) : col;
                state   <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_COPY: begin
          // read one row below, write it back one row up in the next cycle
          cp_pend  <= 1'b1;
          cp_waddr <= AW'(ptr - AW'(tcw_pkg::COLS));
          if (ptr == stop) begin
            state <= S_COPYEND;
          end else begin
            ptr <= AW'(ptr + 1'b1);
          end
        end
        S_COPYEND: begin
          cp_pend <= 1'b0;
          ptr     <= AW'(stop - AW'(tcw_pkg::COLS - 1));
          state   <= S_BLANK;
        end
        S_BLANK: begin
          if (ptr == stop) begin
            state <= S_DONE;
          end else begin
            ptr <= AW'(ptr + 1'b1);
          end
        end
        S_CLEAR: begin
          if (int'(ptr) == tcw_pkg::CELLS - 1) begin
            state <= S_DONE;
          end else begin
            ptr <= AW'(ptr + 1'b1);
          end
        end
        S_DONE: begin
          if (load_result) begin
            read_hit <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded with the valid flag
  always_ff @(posedge clk) begin
    if (load_result) begin
      cursor_row      <= cur_row;
      cursor_col      <= cur_col;
      cursor_offset   <= 11'(tcw_pkg::cell_addr(cur_row, cur_col));
      cursor_enabled  <= cursor_on;
      cell_value      <= read_hit ? ram_rdata : 16'd0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tcw_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/tcw_checker.sv
// port-level checks for the text console writer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tcw_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         item_valid,
  input wire logic                         item_ready,
  input wire logic                         result_valid,
  input wire logic                         result_ready,
  input wire logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  input wire logic [tcw_pkg::COL_W-1:0]    cursor_col,
  input wire logic [10:0]                  cursor_offset,
  input wire logic                         cursor_enabled,
  input wire logic [15:0]                  cell_value
);

  // clearing pass starts right after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> (!item_ready && !result_valid))
    else $error("block ready or result valid right after reset");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken in back to back cycles");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((int'(cursor_row) < tcw_pkg::ROWS) &&
                      (int'(cursor_col) < tcw_pkg::COLS)))
    else $error("cursor outside the screen");

  a_location: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (cursor_offset == 11'(tcw_pkg::cell_addr(cursor_row, cursor_col))))
    else $error("cursor location does not match row and column");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(cursor_offset) && $stable(cell_value) &&
       $stable(cursor_enabled)))
    else $error("stalled result word changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
`default_nettype wire
